// File: rtl/icabu_pkg.sv
// Shared types, widths, tables and saturation helpers for the ICA block updater.
package icabu_pkg;

	localparam int DIMS        = 4;
	localparam int SAMPLE_BITS = 16;

	localparam int IDX_W    = $clog2(DIMS);
	localparam int CNT_W    = $clog2(DIMS + 1);
	localparam int ROW_BITS = 2;

	localparam int FRAC_BITS  = 12;
	localparam int L_SHIFT    = 16;
	localparam int W_SHIFT    = 24;
	localparam int DIAG_SHIFT = 24;

	localparam int LR_BITS = 16;
	localparam int BS_BITS = 8;
	localparam int G_BITS  = 40;
	localparam int Y_BITS  = 13;

	// lane operand widths: A carries W, y, G+bI or L; B carries x, lambda or W
	localparam int A_BITS = G_BITS + 1;
	localparam int B_BITS = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;
	localparam int P_BITS = A_BITS + B_BITS;
	localparam int S_BITS = P_BITS + $clog2(DIMS);
	localparam int SUM_W  = S_BITS + 1;
	localparam int NL_W   = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

	localparam logic [LR_BITS-1:0] LR_RESET = LR_BITS'(66);
	localparam logic [BS_BITS-1:0] BS_RESET = BS_BITS'(16);

	localparam logic signed [SAMPLE_BITS-1:0] ONE_Q = SAMPLE_BITS'(64'd1 << FRAC_BITS);

	localparam logic signed [SUM_W-1:0] SMAX_X = SUM_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic signed [SUM_W-1:0] SMIN_X = ~SMAX_X;
	localparam logic signed [P_BITS:0]  GMAX_X = (P_BITS + 1)'((64'd1 << (G_BITS - 1)) - 64'd1);
	localparam logic signed [P_BITS:0]  GMIN_X = ~GMAX_X;

	// configuration register indexes
	localparam logic REG_LEARN_RATE = 1'b0;
	localparam logic REG_BLOCK_SIZE = 1'b1;

	// result kinds
	localparam logic KIND_ROW    = 1'b0;
	localparam logic KIND_SOURCE = 1'b1;

	localparam logic ACT_TRAIN = 1'b0;
	localparam logic ACT_UNMIX = 1'b1;

	typedef struct packed {
		logic                          action;
		logic signed [SAMPLE_BITS-1:0] sample_0;
		logic signed [SAMPLE_BITS-1:0] sample_1;
		logic signed [SAMPLE_BITS-1:0] sample_2;
		logic signed [SAMPLE_BITS-1:0] sample_3;
	} in_word_t;

	typedef struct packed {
		logic                          kind;
		logic [ROW_BITS-1:0]           row_index;
		logic signed [SAMPLE_BITS-1:0] value_0;
		logic signed [SAMPLE_BITS-1:0] value_1;
		logic signed [SAMPLE_BITS-1:0] value_2;
		logic signed [SAMPLE_BITS-1:0] value_3;
		logic                          last;
	} out_word_t;

	// tanh(k/4) in Q0.12
	function automatic logic [11:0] tanh_q(input logic [4:0] k);
		logic [11:0] t;
		unique case (k)
			5'd0:    t = 12'd0;
			5'd1:    t = 12'd1003;
			5'd2:    t = 12'd1893;
			5'd3:    t = 12'd2602;
			5'd4:    t = 12'd3119;
			5'd5:    t = 12'd3475;
			5'd6:    t = 12'd3707;
			5'd7:    t = 12'd3856;
			5'd8:    t = 12'd3949;
			5'd9:    t = 12'd4006;
			5'd10:   t = 12'd4041;
			5'd11:   t = 12'd4062;
			5'd12:   t = 12'd4076;
			5'd13:   t = 12'd4084;
			5'd14:   t = 12'd4089;
			5'd15:   t = 12'd4091;
			5'd16:   t = 12'd4093;
			default: t = 12'd0;
		endcase
		return t;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
		input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		if (v > SMAX_X)
			r = SMAX_X;
		else if (v < SMIN_X)
			r = SMIN_X;
		else
			r = v;
		return SAMPLE_BITS'(r);
	endfunction

	function automatic logic signed [G_BITS-1:0] sat_grad(input logic signed [P_BITS:0] v);
		logic signed [P_BITS:0] r;
		if (v > GMAX_X)
			r = GMAX_X;
		else if (v < GMIN_X)
			r = GMIN_X;
		else
			r = v;
		return G_BITS'(r);
	endfunction

endpackage

// File: rtl/icabu_lane.sv
// One multiply lane: registered signed product of two operands.
module icabu_lane (
	input  logic                                  clk,
	input  logic signed [icabu_pkg::A_BITS-1:0]   a,
	input  logic signed [icabu_pkg::B_BITS-1:0]   b,
	output logic signed [icabu_pkg::P_BITS-1:0]   prod_s1
);
	import icabu_pkg::*;

	always_ff @(posedge clk) begin
		prod_s1 <= P_BITS'(a) * P_BITS'(b);
	end

endmodule

// File: rtl/icabu_merge.sv
// Adder tree that merges the lane products into one dot-product sum.
module icabu_merge (
	input  logic signed [icabu_pkg::P_BITS-1:0] prod [icabu_pkg::DIMS],
	output logic signed [icabu_pkg::S_BITS-1:0] sum
);
	import icabu_pkg::*;

	always_comb begin
		logic signed [S_BITS-1:0] acc;
		acc = '0;
		for (int k = 0; k < DIMS; k++)
			acc = acc + S_BITS'(prod[k]);
		sum = acc;
	end

endmodule

// File: rtl/icabu_nonlin.sv
// y = -tanh(u/2) by table lookup with linear interpolation.
module icabu_nonlin (
	input  logic signed [icabu_pkg::SAMPLE_BITS-1:0] u,
	output logic signed [icabu_pkg::Y_BITS-1:0]      y
);
	import icabu_pkg::*;

	logic signed [SAMPLE_BITS:0] ue;
	logic [SAMPLE_BITS:0]        abs_v;
	logic [NL_W:0]               a;
	logic [NL_W-11:0]            idx;
	logic [3:0]                  k;
	logic [10:0]                 f;
	logic [11:0]                 t0, t1, diff, mag;
	logic [22:0]                 slope;

	assign ue    = (SAMPLE_BITS + 1)'(u);
	assign abs_v = (u < 0) ? (SAMPLE_BITS + 1)'(-ue) : (SAMPLE_BITS + 1)'(ue);
	assign a     = (NL_W + 1)'(abs_v);
	assign idx   = a[NL_W:11];
	assign k     = idx[3:0];
	assign f     = a[10:0];
	assign t0    = tanh_q({1'b0, k});
	assign t1    = tanh_q({1'b0, k} + 5'd1);
	assign diff  = t1 - t0;
	assign slope = 23'(diff) * 23'(f);
	assign mag   = (idx >= (NL_W - 10)'(16)) ? tanh_q(5'd16) : t0 + slope[22:11];
	assign y     = (u >= 0) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule

// File: rtl/infomax_ica_block_update_top.sv
// Top level: infomax ICA learner with DIMS multiply lanes and a merge tree.
// Unmix word: accept, projection over the rows, then a load into the output register.
// Train word inside a block: projection, nonlinearity, gradient; then the next word.
// Block end adds the lambda*(G+bI) pass, the matrix product, the commit state and the
// row emission, which waits while the output stalls. One word at a time; the lanes
// take one row per cycle, except in the matrix product. arst_n low gives
// W = identity, G = 0, count = 0, learn_rate 66, block_size 16, no pending result.
module infomax_ica_block_update_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  icabu_pkg::in_word_t    in_word,
	output logic                   out_valid,
	input  logic                   out_stall,
	output icabu_pkg::out_word_t   out_word,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_index,
	input  logic [15:0]            cfg_data
);
	import icabu_pkg::*;

	// sequencer phases
	typedef enum logic [3:0] {
		S_IDLE, S_PROJ, S_SRC, S_NL, S_GRAD, S_LM, S_MUL, S_COMMIT, S_ROWS
	} state_t;

	// what the writeback stage does with the lane products
	typedef enum logic [1:0] {WB_PROJ, WB_GRAD, WB_LM, WB_MUL} wb_op_t;

	typedef struct packed {
		logic             valid;
		wb_op_t           op;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} wb_t;

	state_t           state_q;
	logic [CNT_W-1:0] ri_q;
	logic [IDX_W-1:0] cj_q;
	logic [IDX_W-1:0] ri_idx;
	logic             issuing;
	wb_t              wb_s1;

	logic [LR_BITS-1:0] lr_q;
	logic [BS_BITS-1:0] bs_q;
	logic [BS_BITS-1:0] bsz;
	logic [BS_BITS-1:0] count_q;
	logic               block_end;

	// matrices
	logic signed [SAMPLE_BITS-1:0] w_q  [DIMS][DIMS];
	logic signed [SAMPLE_BITS-1:0] nw_q [DIMS][DIMS];
	logic signed [G_BITS-1:0]      g_q  [DIMS][DIMS];
	logic signed [A_BITS-1:0]      l_q  [DIMS][DIMS];

	// per-word vectors
	logic signed [SAMPLE_BITS-1:0] x_q [DIMS];
	logic signed [SAMPLE_BITS-1:0] u_q [DIMS];
	logic signed [Y_BITS-1:0]      y_q [DIMS];
	logic signed [Y_BITS-1:0]      y_c [DIMS];
	logic                          act_q;

	// lanes
	logic signed [A_BITS-1:0] lane_a [DIMS];
	logic signed [B_BITS-1:0] lane_b [DIMS];
	logic signed [P_BITS-1:0] prod_s1 [DIMS];
	logic signed [S_BITS-1:0] sum;
	logic signed [A_BITS-1:0] diag;

	logic      out_valid_q;
	out_word_t out_word_q;
	logic      out_free, load_src, load_row, accept;

	assign ri_idx    = ri_q[IDX_W-1:0];
	assign issuing   = ri_q < CNT_W'(DIMS);
	assign bsz       = (bs_q == '0) ? BS_BITS'(1) : bs_q;
	assign block_end = ({1'b0, count_q} + (BS_BITS + 1)'(1)) >= {1'b0, bsz};
	assign diag      = A_BITS'({bsz, {DIAG_SHIFT{1'b0}}});

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign load_src  = (state_q == S_SRC) && out_free;
	assign load_row  = (state_q == S_ROWS) && out_free;

	// lane operand select: lane k always works on column k of the current row
	always_comb begin
		for (int k = 0; k < DIMS; k++) begin
			lane_a[k] = '0;
			lane_b[k] = '0;
			unique case (state_q)
				S_PROJ: begin
					lane_a[k] = A_BITS'(w_q[ri_idx][k]);
					lane_b[k] = B_BITS'(x_q[k]);
				end
				S_GRAD: begin
					lane_a[k] = A_BITS'(y_q[ri_idx]);
					lane_b[k] = B_BITS'(x_q[k]);
				end
				S_LM: begin
					lane_a[k] = A_BITS'(g_q[ri_idx][k]) +
						((ri_idx == IDX_W'(k)) ? diag : '0);
					lane_b[k] = B_BITS'({1'b0, lr_q});
				end
				S_MUL: begin
					lane_a[k] = l_q[ri_idx][k];
					lane_b[k] = B_BITS'(w_q[k][cj_q]);
				end
				default: begin
					lane_a[k] = '0;
					lane_b[k] = '0;
				end
			endcase
		end
	end

	for (genvar k = 0; k < DIMS; k++) begin : g_lane
		icabu_lane u_lane (
			.clk     (clk),
			.a       (lane_a[k]),
			.b       (lane_b[k]),
			.prod_s1 (prod_s1[k])
		);

		icabu_nonlin u_nonlin (
			.u (u_q[k]),
			.y (y_c[k])
		);
	end

	icabu_merge u_merge (
		.prod (prod_s1),
		.sum  (sum)
	);

	// control, configuration, W, G and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ri_q        <= '0;
			cj_q        <= '0;
			wb_s1       <= '0;
			lr_q        <= LR_RESET;
			bs_q        <= BS_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DIMS; i++)
				for (int j = 0; j < DIMS; j++) begin
					w_q[i][j] <= (i == j) ? ONE_Q : '0;
					g_q[i][j] <= '0;
				end
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_LEARN_RATE: lr_q <= cfg_data;
					REG_BLOCK_SIZE: bs_q <= cfg_data[BS_BITS-1:0];
				endcase
			end

			// a loaded word stays valid until it leaves unstalled
			out_valid_q <= load_src || load_row || (out_valid_q && out_stall);

			// gradient accumulation writeback
			if (wb_s1.valid && wb_s1.op == WB_GRAD) begin
				for (int k = 0; k < DIMS; k++)
					g_q[wb_s1.row][k] <= sat_grad((P_BITS + 1)'(g_q[wb_s1.row][k]) +
						(P_BITS + 1)'(prod_s1[k]));
			end

			wb_s1.valid <= issuing && (state_q == S_PROJ || state_q == S_GRAD ||
				state_q == S_LM || state_q == S_MUL);
			wb_s1.row   <= ri_idx;
			wb_s1.col   <= cj_q;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_PROJ;
						ri_q    <= '0;
					end
				end
				S_PROJ: begin
					if (issuing) begin
						wb_s1.op    <= WB_PROJ;
						ri_q        <= ri_q + CNT_W'(1);
					end else begin
						ri_q    <= '0;
						state_q <= (act_q == ACT_UNMIX) ? S_SRC : S_NL;
					end
				end
				S_SRC: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				S_NL: begin
					state_q <= S_GRAD;
				end
				S_GRAD: begin
					if (issuing) begin
						wb_s1.op    <= WB_GRAD;
						ri_q        <= ri_q + CNT_W'(1);
					end else begin
						ri_q <= '0;
						if (block_end) begin
							state_q <= S_LM;
						end else begin
							count_q <= count_q + BS_BITS'(1);
							state_q <= S_IDLE;
						end
					end
				end
				S_LM: begin
					if (issuing) begin
						wb_s1.op    <= WB_LM;
						ri_q        <= ri_q + CNT_W'(1);
					end else begin
						ri_q    <= '0;
						cj_q    <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					// one element of the new W per cycle, row-major
					if (issuing) begin
						wb_s1.op    <= WB_MUL;
						if (cj_q == IDX_W'(DIMS - 1)) begin
							cj_q <= '0;
							ri_q <= ri_q + CNT_W'(1);
						end else begin
							cj_q <= cj_q + IDX_W'(1);
						end
					end else begin
						ri_q    <= '0;
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					for (int i = 0; i < DIMS; i++)
						for (int j = 0; j < DIMS; j++) begin
							w_q[i][j] <= nw_q[i][j];
							g_q[i][j] <= '0;
						end
					count_q <= '0;
					state_q <= S_ROWS;
				end
				S_ROWS: begin
					if (out_free) begin
						if (ri_idx == IDX_W'(DIMS - 1)) begin
							ri_q    <= '0;
							state_q <= S_IDLE;
						end else begin
							ri_q <= ri_q + CNT_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= in_word.action;
			x_q[0] <= in_word.sample_0;
			x_q[1] <= in_word.sample_1;
			x_q[2] <= in_word.sample_2;
			x_q[3] <= in_word.sample_3;
		end

		if (state_q == S_NL)
			y_q <= y_c;

		if (wb_s1.valid) begin
			unique case (wb_s1.op)
				WB_PROJ: u_q[wb_s1.row] <= sat_sample(SUM_W'(sum >>> FRAC_BITS));
				WB_LM: begin
					for (int k = 0; k < DIMS; k++)
						l_q[wb_s1.row][k] <= A_BITS'(prod_s1[k] >>> L_SHIFT);
				end
				WB_MUL: nw_q[wb_s1.row][wb_s1.col] <= sat_sample(SUM_W'(sum >>> W_SHIFT) +
					SUM_W'(w_q[wb_s1.row][wb_s1.col]));
				WB_GRAD: ;
			endcase
		end

		if (load_src) begin
			out_word_q.kind      <= KIND_SOURCE;
			out_word_q.row_index <= '0;
			out_word_q.value_0   <= u_q[0];
			out_word_q.value_1   <= u_q[1];
			out_word_q.value_2   <= u_q[2];
			out_word_q.value_3   <= u_q[3];
			out_word_q.last      <= 1'b1;
		end else if (load_row) begin
			out_word_q.kind      <= KIND_ROW;
			out_word_q.row_index <= ROW_BITS'(ri_idx);
			out_word_q.value_0   <= w_q[ri_idx][0];
			out_word_q.value_1   <= w_q[ri_idx][1];
			out_word_q.value_2   <= w_q[ri_idx][2];
			out_word_q.value_3   <= w_q[ri_idx][3];
			out_word_q.last      <= (ri_idx == IDX_W'(DIMS - 1));
		end
	end

endmodule

// File: rtl/icabu_checker.sv
// Port-level checker for the ICA block updater, bound to the top level.
module icabu_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input icabu_pkg::out_word_t out_word
);
	import icabu_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// one word at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while a word is in flight");

	// source estimates are single, final words at row zero
	a_source_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.kind == KIND_SOURCE |-> out_word.last &&
			out_word.row_index == '0)
		else $error("malformed source word");

	// only the final matrix row carries last
	a_row_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.kind == KIND_ROW |->
			out_word.last == (out_word.row_index == ROW_BITS'(DIMS - 1)))
		else $error("last flag on wrong matrix row");

	// nothing emitted directly after an accept
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind infomax_ica_block_update_top icabu_checker u_icabu_checker (.*);
